// ===== src/cti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cti_pkg;

    // table size and derived widths
    localparam int POINTS = 8;
    localparam int PTR_W  = $clog2(POINTS);

    // divider: 32-bit dividend magnitude, 16-bit divisor, one quotient bit a step
    localparam int DIV_W = 32;
    localparam int DEN_W = 16;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  point_index;
        logic [15:0] point_reading;
        logic [15:0] point_output;
        logic [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0] expected_value;
        logic [2:0]  segment;
        logic        saturated;
    } t_out_item;

    // one calibration point as stored in the table memory
    typedef struct packed {
        logic [15:0] reading;
        logic [15:0] value;
    } t_point;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/calibration_table_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// piecewise linear calibration lookup. a write transaction (operation 0) stores one
// point and returns nothing; a point_index beyond the table is dropped. a query
// transaction (operation 1) walks the table one entry per cycle through its memory
// port, picks a segment and, unless the start value is the answer, multiplies once
// and runs a one bit per cycle divider, then returns one result. a flat or falling
// segment, or a sample at or below the first point, skips the multiply and divider;
// otherwise the segment walk over the single read port and the 32-step divider take
// up most of a query's time. one item is handled at a time, but a result waiting in
// the output register does not block acceptance of the next transaction.
// table entries that were never written read back undefined.
module calibration_table_interpolator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cti_pkg::t_in_item   i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cti_pkg::t_out_item       o_out
);
    import cti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [PTR_W-1:0] r_k;
    logic [15:0]      r_sample;
    logic [15:0]      r_x0, r_y0, r_x1, r_y1;
    logic signed [33:0] r_prod;
    logic             r_neg;
    logic [15:0]      r_res;
    logic             r_sat;
    logic             r_out_valid;
    t_out_item        r_out;

    // memory port
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    t_point           ram_wdata;
    logic [PTR_W-1:0] ram_raddr;
    t_point           ram_rdata;

    // divider
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             in_fire;
    logic             out_free;
    logic             scan_stop;
    logic             direct;
    logic signed [16:0] dx, dy;
    logic [33:0]      prod_mag;
    logic signed [33:0] q_signed;
    logic signed [33:0] val;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // writes go straight to the table; an index beyond the table is dropped
    assign ram_we    = in_fire && (i_in.operation == OP_WRITE)
                       && (32'(i_in.point_index) < POINTS);
    assign ram_waddr = PTR_W'(i_in.point_index);
    assign ram_wdata = '{reading: i_in.point_reading, value: i_in.point_output};

    // read address runs one step ahead of the entry being compared
    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_raddr = '0;
            S_FIRST: ram_raddr = PTR_W'(1);
            S_SCAN:  ram_raddr = r_k + PTR_W'(2);
            default: ram_raddr = '0;
        endcase
    end

    cti_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // segment k ends the walk when it does not rise, when its end covers the
    // sample, or when it is the last segment of the table
    assign scan_stop = (ram_rdata.reading <= r_x0)
                       || (r_sample <= ram_rdata.reading)
                       || (r_k == PTR_W'(POINTS - 2));

    // start value is the answer below the first point and on a flat or falling segment
    assign direct = ((r_k == '0) && (r_sample <= r_x0)) || (r_x1 <= r_x0);

    assign dx = $signed({1'b0, r_sample}) - $signed({1'b0, r_x0});
    assign dy = $signed({1'b0, r_y1}) - $signed({1'b0, r_y0});

    // divide the magnitude, then restore the sign: truncation toward zero
    assign prod_mag = r_neg ? 34'(-r_prod) : 34'(r_prod);

    assign div_req.start    = (r_state == S_DSTART);
    assign div_req.dividend = prod_mag[DIV_W-1:0];
    assign div_req.divisor  = r_x1 - r_x0;

    cti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign q_signed = r_neg ? -$signed({2'b00, div_rsp.quotient})
                            :  $signed({2'b00, div_rsp.quotient});
    assign val      = q_signed + $signed({18'b0, r_y0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a result taken downstream frees the register, unless a new one loads now
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in.operation == OP_QUERY)) begin
                        r_sample <= i_in.sample;
                        r_state  <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_x0    <= ram_rdata.reading;
                    r_y0    <= ram_rdata.value;
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_stop) begin
                        r_x1    <= ram_rdata.reading;
                        r_y1    <= ram_rdata.value;
                        r_state <= S_MUL;
                    end else begin
                        r_x0 <= ram_rdata.reading;
                        r_y0 <= ram_rdata.value;
                        r_k  <= r_k + PTR_W'(1);
                    end
                end
                S_MUL: begin
                    if (direct) begin
                        r_res   <= r_y0;
                        r_sat   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_prod  <= 34'(dx * dy);
                        r_neg   <= dy[16];
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        // clamp to the 16-bit output range, flag the top clamp
                        if (val[33]) begin
                            r_res <= '0;
                            r_sat <= 1'b0;
                        end else if (val > 34'sd65535) begin
                            r_res <= 16'hFFFF;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= val[15:0];
                            r_sat <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_out.expected_value <= r_res;
                        r_out.segment        <= 3'(r_k);
                        r_out.saturated      <= r_sat;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== src/cti_table_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cti_table_ram (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [cti_pkg::PTR_W-1:0] i_waddr,
    input  wire cti_pkg::t_point       i_wdata,
    input  wire logic [cti_pkg::PTR_W-1:0] i_raddr,
    output cti_pkg::t_point            o_rdata
);
    import cti_pkg::*;

    t_point r_mem [POINTS];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/cti_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cti_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cti_pkg::t_div_req i_req,
    output cti_pkg::t_div_rsp      o_rsp
);
    import cti_pkg::*;

    logic [DEN_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   trial;
    logic             fits;

    // restoring step: shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], fits};
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/cti_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cti_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire cti_pkg::t_in_item  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire cti_pkg::t_out_item o_out
);
    import cti_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // segment never passes the last one
    a_segment_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.segment) <= POINTS - 2))
        else $error("segment out of range");

    // saturation only with the clamped maximum
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |-> (o_out.expected_value == 16'hFFFF))
        else $error("saturated without full-scale value");

    // a point write does not hold up the input: it is ready again in the next cycle
    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.operation == OP_WRITE) |=> o_in_ready)
        else $error("write transaction stalled the input");

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

// ===== test/calibration_table_interpolator_tb.sv =====
`timescale 1ns / 1ps

module calibration_table_interpolator_tb;

    import cti_pkg::*;

    // idle chance per cycle on each side, in percent
    localparam int IDLE_PCT = 35;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // give the block time to settle at the end
    localparam int DRAIN_CYCLES = 64;
    // random part: table loads, each followed by a burst of mostly queries
    localparam int TABLE_ROUNDS = 60;
    localparam int ITEMS_PER_ROUND = 24;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // mirror of the calibration table, updated as write transactions are accepted
    logic [15:0] cal_reading [POINTS];
    logic [15:0] cal_value [POINTS];

    t_out_item   expected_results[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;     // when set neither side idles
    int          stall_cycles = 0;

    calibration_table_interpolator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // piecewise linear lookup of one sample against the mirrored table
    function automatic t_out_item interpolate_sample(input logic [15:0] smp);
        t_out_item res;
        int        k;
        longint    x0, x1, y0, y1, xs, val;
        // walk segments from the first; stop on a non-rising one or one that covers the sample
        for (k = 0; k < POINTS - 1; k++) begin
            if (cal_reading[k] >= cal_reading[k + 1]) break;
            if (smp <= cal_reading[k + 1]) break;
        end
        // nothing stopped the walk: extrapolate from the last segment
        if (k > POINTS - 2) k = POINTS - 2;
        x0 = longint'(cal_reading[k]);
        x1 = longint'(cal_reading[k + 1]);
        y0 = longint'(cal_value[k]);
        y1 = longint'(cal_value[k + 1]);
        xs = longint'(smp);
        res.segment = k[2:0];
        res.saturated = 1'b0;
        if ((k == 0 && xs <= x0) || x1 <= x0) begin
            // below the first point, or a flat / falling segment: start value
            res.expected_value = y0[15:0];
        end else begin
            // signed longint division truncates toward zero
            val = (xs - x0) * (y1 - y0) / (x1 - x0) + y0;
            if (val < 0) begin
                res.expected_value = 16'd0;
            end else if (val > 65535) begin
                res.expected_value = 16'hFFFF;
                res.saturated = 1'b1;
            end else begin
                res.expected_value = val[15:0];
            end
        end
        return res;
    endfunction

    // monitor: both channels are sampled at the falling edge, which holds the
    // values that the next rising edge will act on
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no query outstanding: value %0d segment %0d",
                           out_item.expected_value, out_item.segment);
                    failed = 1'b1;
                end else begin
                    t_out_item exp_res;
                    exp_res = expected_results.pop_front();
                    if (out_item.expected_value !== exp_res.expected_value) begin
                        $error("expected_value: expected %0d, got %0d",
                               exp_res.expected_value, out_item.expected_value);
                        failed = 1'b1;
                    end
                    if (out_item.segment !== exp_res.segment) begin
                        $error("segment: expected %0d, got %0d",
                               exp_res.segment, out_item.segment);
                        failed = 1'b1;
                    end
                    if (out_item.saturated !== exp_res.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_res.saturated, out_item.saturated);
                        failed = 1'b1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (in_item.operation == OP_WRITE) begin
                    // indexes past the table are dropped by the block
                    if (in_item.point_index < POINTS) begin
                        cal_reading[in_item.point_index] = in_item.point_reading;
                        cal_value[in_item.point_index] = in_item.point_output;
                    end
                end else begin
                    expected_results.push_back(interpolate_sample(in_item.sample));
                end
            end
        end
    end

    // watchdog: a run that moves no transaction for too long is hung
    always @(negedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("calibration_table_interpolator_tb: FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // offer one transaction, idling first at random; returns at the edge that takes it
    // and leaves valid high, so the next call or the end of stimulus decides its level
    task automatic send_item(input t_in_item item);
        bit taken;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= item;
        in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic write_point(input int idx, input int reading, input int value);
        t_in_item item;
        item = '0;
        item.operation = OP_WRITE;
        item.point_index = idx[2:0];
        item.point_reading = reading[15:0];
        item.point_output = value[15:0];
        // sample is a don't-care on writes, keep it moving
        item.sample = 16'($urandom);
        send_item(item);
    endtask

    task automatic query_sample(input int smp);
        t_in_item item;
        item = '0;
        item.operation = OP_QUERY;
        item.point_index = 3'($urandom);
        item.point_reading = 16'($urandom);
        item.point_output = 16'($urandom);
        item.sample = smp[15:0];
        send_item(item);
    endtask

    // base table: readings 1000..64000, values 0..63000, every entry written
    // before any query so that no query reads an unwritten entry
    task automatic test_table_load();
        for (int i = 0; i < POINTS; i++) begin
            write_point(i, 1000 + i * 9000, i * 9000);
        end
    endtask

    // below, at, between and past the calibration points
    task automatic test_query_points();
        query_sample(0);       // below the first point
        query_sample(1000);    // exactly on the first point
        query_sample(5500);    // inside segment 0
        query_sample(64000);   // exactly on the last point
        query_sample(65535);   // extrapolated off the last segment
    endtask

    // result range limits on the last segment
    task automatic test_clamping();
        // steep rise: extrapolation overflows and saturates
        write_point(7, 55001, 65535);
        query_sample(65535);
        // steep fall: extrapolation goes negative and clamps to zero
        write_point(7, 56000, 0);
        query_sample(65535);
    endtask

    // segments whose end reading does not rise above the start
    task automatic test_flat_segments();
        // point 3 below point 2: the walk stops at segment 2
        write_point(3, 10000, 0);
        query_sample(30000);
        // first point at full scale: segment 0 is falling
        write_point(0, 65535, 1234);
        query_sample(40000);
        // first point at zero reading with full scale value
        write_point(0, 0, 65535);
        query_sample(0);
    endtask

    // pick a sample that lands on, near, between or far from the table points
    function automatic int pick_sample();
        int s;
        case ($urandom_range(9))
            0: s = 0;
            1: s = 65535;
            2, 3, 4, 5: begin
                s = int'(cal_reading[$urandom_range(POINTS - 1)]) + $urandom_range(6) - 3;
                if (s < 0) s = 0;
                if (s > 65535) s = 65535;
            end
            default: s = $urandom_range(65535);
        endcase
        return s;
    endfunction

    // load a whole table of random content in a random rotation
    task automatic load_random_table();
        int rd [POINTS];
        int val [POINTS];
        int rot;
        int kind;
        kind = $urandom_range(9);
        if (kind < 4) begin
            // dense rising readings with some repeats: steep slopes, overflow, flat steps
            rd[0] = $urandom_range(65535 - POINTS * 40);
            for (int i = 1; i < POINTS; i++) rd[i] = rd[i - 1] + $urandom_range(40);
        end else if (kind < 8) begin
            // wide rising readings
            for (int i = 0; i < POINTS; i++) rd[i] = $urandom_range(65535);
            rd.sort();
        end else begin
            // unsorted noise
            for (int i = 0; i < POINTS; i++) rd[i] = $urandom_range(65535);
        end
        for (int i = 0; i < POINTS; i++) val[i] = $urandom_range(65535);
        if ($urandom_range(1)) val.sort();
        rot = $urandom_range(POINTS - 1);
        for (int j = 0; j < POINTS; j++) begin
            int idx;
            idx = (j + rot) % POINTS;
            write_point(idx, rd[idx], val[idx]);
        end
    endtask

    task automatic test_random_tables();
        for (int r = 0; r < TABLE_ROUNDS; r++) begin
            // one stretch of rounds runs at full rate on both sides
            quiet = (r >= 20 && r < 28);
            load_random_table();
            for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
                if ($urandom_range(9) == 0) begin
                    // stray single point rewrite
                    write_point($urandom_range(POINTS - 1), $urandom_range(65535),
                                $urandom_range(65535));
                end else begin
                    query_sample(pick_sample());
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        out_ready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_query_points();
        test_clamping();
        test_flat_segments();
        test_random_tables();

        // last transaction was taken at this edge; stop offering
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed) begin
            $display("calibration_table_interpolator_tb: PASS");
        end else begin
            $display("calibration_table_interpolator_tb: FAIL");
        end
        $finish;
    end

endmodule
